[hdl/t2f_pkg.sv]
// Shared types, constants and the symbol builder for the track 2 F2F encoder.
// Used by t2f_front, t2f_queue, t2f_back and the top level. No dependencies.
package t2f_pkg;

  localparam int unsigned BitsPerChar = 5;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CntW        = $clog2(BitsPerChar);
  localparam int unsigned QPtrW       = $clog2(QueueDepth);

  localparam logic [7:0] CharLow  = 8'h30;  // '0'
  localparam logic [7:0] CharHigh = 8'h3F;  // '?'

  typedef enum logic [1:0] {
    MODE_DATA   = 2'd0,
    MODE_PAD    = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef logic [BitsPerChar-1:0] sym_t;

  // One queued character: five cells, LSB first, plus the bad-character flag
  typedef struct packed {
    sym_t sym;
    logic bad;
  } sym_entry_t;

  // Queue status as seen by the front and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  // Nibble in bits 0..3, odd parity in bit 4
  function automatic sym_t make_symbol(input logic [3:0] nib);
    make_symbol = {~(^nib), nib};
  endfunction

endpackage

[hdl/track2_f2f_stripe_encoder.sv]
// Top level of the track 2 F2F (Aiken biphase) stripe encoder.
// Depends on t2f_pkg, t2f_front, t2f_queue and t2f_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per character:
//   in_mode 0 sends in_char_code as a data character (outside '0'..'?' it
//   goes out as 11111 with bad_char set), 1 sends a zero pad character,
//   2 sends the LRC character and clears the LRC, 3 is taken and dropped.
//   Output channel (out_valid / out_stall): five transactions per character,
//   one per bit cell, LSB first, each carrying both half-cell coil levels;
//   out_last_bit marks the fifth cell.
//   A character passes from the front into the queue, into the shifter and
//   then into the output register before its first cell leaves.
//   Throughput: one cell per cycle while out_stall does not hold the output,
//   set by the single bit-cell shifter in the back end.
//   A two-entry queue lets the front keep taking characters while the back
//   is still shifting; in_stall rises only when that queue is full.
//   When out_stall is high and out_valid is set, the output register and
//   shifter hold; the queue then fills and stalls the input side.
//   Reset (rst_n low, synchronous) clears the coil level, the LRC, the
//   queue and all valid flags.
module track2_f2f_stripe_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_first_half_level,
  output logic       out_second_half_level,
  output logic       out_bad_char,
  output logic       out_last_bit
);
  import t2f_pkg::*;

  q_stat_t    q_stat;
  logic       push, pop;
  sym_entry_t push_entry, head;

  // Classify and build symbols; keep the LRC in transaction order
  t2f_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Decouple the front from the cell shifter
  t2f_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Emit one bit cell per cycle while not stalled, and track the coil
  t2f_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .head                  (head),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_first_half_level  (out_first_half_level),
    .out_second_half_level (out_second_half_level),
    .out_bad_char          (out_bad_char),
    .out_last_bit          (out_last_bit)
  );

endmodule

[hdl/t2f_front.sv]
// Front end: accepts input transactions, classifies them, builds the symbol
// and keeps the LRC. Depends on t2f_pkg.
module t2f_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_char_code,
  input  t2f_pkg::q_stat_t    q_stat,
  output logic                push,
  output t2f_pkg::sym_entry_t push_entry
);
  import t2f_pkg::*;

  logic [3:0] lrc_r, lrc_nxt;
  logic       accept;
  logic       in_range;
  logic [3:0] nib;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign in_range = (in_char_code >= CharLow) && (in_char_code <= CharHigh);
  assign nib      = in_range ? in_char_code[3:0] : 4'hF;

  always_comb begin
    push             = 1'b0;
    push_entry.sym   = '0;
    push_entry.bad   = 1'b0;
    lrc_nxt          = lrc_r;
    case (mode_t'(in_mode))
      MODE_DATA: begin
        push           = accept;
        push_entry.sym = in_range ? make_symbol(nib) : '1;
        push_entry.bad = !in_range;
        if (accept) lrc_nxt = lrc_r ^ nib;
      end
      MODE_PAD: begin
        push = accept;
      end
      MODE_FINISH: begin
        push           = accept;
        push_entry.sym = make_symbol(lrc_r);
        if (accept) lrc_nxt = '0;
      end
      default: begin
        // unused mode: accept and drop
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrc_r <= '0;
    end else begin
      lrc_r <= lrc_nxt;
    end
  end

endmodule

[hdl/t2f_queue.sv]
// Short queue of classified characters between front and back.
// Depends on t2f_pkg.
module t2f_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  t2f_pkg::sym_entry_t push_entry,
  input  logic                pop,
  output t2f_pkg::sym_entry_t head,
  output t2f_pkg::q_stat_t    q_stat
);
  import t2f_pkg::*;

  sym_entry_t           mem_r [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]       count_r;

  assign q_stat.full     = (count_r == (QPtrW+1)'(QueueDepth));
  assign q_stat.nonempty = (count_r != '0);
  assign head            = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/t2f_back.sv]
// Back end: unless stalled, shifts out one F2F bit cell per cycle into the
// output register and tracks the coil level. Depends on t2f_pkg.
module t2f_back (
  input  logic                clk,
  input  logic                rst_n,
  input  t2f_pkg::q_stat_t    q_stat,
  input  t2f_pkg::sym_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_first_half_level,
  output logic                out_second_half_level,
  output logic                out_bad_char,
  output logic                out_last_bit
);
  import t2f_pkg::*;

  sym_t            sym_r;
  logic            bad_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            coil_r;
  logic            out_valid_r;
  logic            first_r, second_r, obad_r, olast_r;
  logic            adv, last, first_lvl;

  assign adv       = !out_valid_r || !out_stall;
  assign last      = (cnt_r == CntW'(BitsPerChar - 1));
  assign first_lvl = ~coil_r;
  assign pop       = adv && q_stat.nonempty && (!busy_r || last);

  assign out_valid             = out_valid_r;
  assign out_first_half_level  = first_r;
  assign out_second_half_level = second_r;
  assign out_bad_char          = obad_r;
  assign out_last_bit          = olast_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      coil_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= busy_r;
      if (busy_r) begin
        coil_r <= first_lvl ^ sym_r[0];
        if (last) begin
          busy_r <= q_stat.nonempty;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (q_stat.nonempty) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy_r) begin
        first_r  <= first_lvl;
        second_r <= first_lvl ^ sym_r[0];
        obad_r   <= bad_r;
        olast_r  <= last;
      end
      if (pop) begin
        sym_r <= head.sym;
        bad_r <= head.bad;
      end else if (busy_r) begin
        sym_r <= sym_r >> 1;
      end
    end
  end

endmodule
